/* rtl/flrx_pkg.sv */
// shared constants, codes and types for the framed link receiver
package flrx_pkg;

  // frame store geometry
  localparam int FRAME_DEPTH  = 256;
  localparam int HEADER_BYTES = 8;
  localparam int IDX_W        = $clog2(FRAME_DEPTH);
  localparam int POS_W        = $clog2(FRAME_DEPTH + 1);
  localparam int RAM_DEPTH    = 2 * (2 ** IDX_W);
  localparam int MAX_LEN      = FRAME_DEPTH - HEADER_BYTES - 1;

  // fixed field widths
  localparam int MODE_W = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 9;

  // configuration port
  localparam int                   CFG_ADDR_W       = 3;
  localparam int                   CFG_DATA_W       = 32;
  localparam logic                 REG_START_MARKER = 1'b0;
  localparam logic [BYTE_W-1:0]    START_RESET      = 8'hFC;

  // item mode codes
  localparam logic [MODE_W-1:0] MODE_BYTE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACK  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP  = 2'd3;

  // classified operation
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_READ,
    OP_ACK,
    OP_NOP
  } op_t;

  // queue entry between front and back
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] index;
    logic              is_start;
    logic              len_bad;
  } qitem_t;

endpackage

/* rtl/flrx_if.sv */
// item and result channel interfaces

interface flrx_item_if;
  logic                            valid;
  logic                            ready;
  logic [flrx_pkg::MODE_W-1:0]     mode;
  logic [flrx_pkg::BYTE_W-1:0]     rx_byte;
  logic [flrx_pkg::BYTE_W-1:0]     read_index;

  modport source(output valid, mode, rx_byte, read_index, input ready);
  modport sink(input valid, mode, rx_byte, read_index, output ready);
endinterface

interface flrx_result_if;
  logic                            valid;
  logic                            ready;
  logic                            frame_ready;
  logic [flrx_pkg::LEN_W-1:0]      frame_length;
  logic [flrx_pkg::BYTE_W-1:0]     read_data;
  logic                            frame_done;
  logic                            checksum_error;
  logic                            length_error;

  modport source(output valid, frame_ready, frame_length, read_data, frame_done,
                 checksum_error, length_error, input ready);
  modport sink(input valid, frame_ready, frame_length, read_data, frame_done,
               checksum_error, length_error, output ready);
endinterface

/* rtl/flrx_ram.sv */
// generic single write port ram with registered read
module flrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port, read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/flrx_front.sv */
// front end: accepts items, classifies them and queues them for the back end
module flrx_front (
  input  logic                        clk,
  input  logic                        rst,
  flrx_item_if.sink                   item,
  input  logic [flrx_pkg::BYTE_W-1:0] start_marker,
  output logic                        q_valid,
  output flrx_pkg::qitem_t            q_head,
  input  logic                        q_pop
);

  localparam logic [1:0] QDEPTH = 2'd2;

  flrx_pkg::qitem_t entry;
  flrx_pkg::qitem_t slot [2];
  logic [1:0]       count;
  logic             wr_ptr;
  logic             rd_ptr;
  logic             push;
  logic             pop;

  // decode mode and precompute byte checks
  always_comb begin
    entry.data     = item.rx_byte;
    entry.index    = item.read_index;
    entry.is_start = (item.rx_byte == start_marker);
    entry.len_bad  = (item.rx_byte == '0) ||
                     (flrx_pkg::LEN_W'(item.rx_byte) >
                      flrx_pkg::LEN_W'(flrx_pkg::MAX_LEN));
    unique case (item.mode)
      flrx_pkg::MODE_BYTE: entry.op = flrx_pkg::OP_BYTE;
      flrx_pkg::MODE_READ: entry.op = flrx_pkg::OP_READ;
      flrx_pkg::MODE_ACK:  entry.op = flrx_pkg::OP_ACK;
      flrx_pkg::MODE_NOP:  entry.op = flrx_pkg::OP_NOP;
      default:             entry.op = flrx_pkg::OP_NOP;
    endcase
  end

  // queue handshake
  assign item.ready = (count != QDEPTH);
  assign push       = item.valid && item.ready;
  assign q_valid    = (count != 2'd0);
  assign pop        = q_pop && q_valid;
  assign q_head     = slot[rd_ptr];

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= entry;
    end
  end

endmodule

/* rtl/flrx_back.sv */
// back end: frame receive state, double buffer and result register
module flrx_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  flrx_pkg::qitem_t q_head,
  output logic             q_pop,
  flrx_result_if.source    result
);

  typedef enum logic [2:0] {
    HUNT,
    GET_LENGTH,
    GET_HEADER,
    GET_PAYLOAD,
    GET_CHECK
  } phase_t;

  localparam logic [2:0] HDR_LAST = 3'(flrx_pkg::HEADER_BYTES - 3);
  localparam int         RAM_AW   = $clog2(flrx_pkg::RAM_DEPTH);

  // receive state
  phase_t                        rx_phase, rx_phase_next;
  logic [2:0]                    hdr_count, hdr_count_next;
  logic [flrx_pkg::BYTE_W-1:0]   running_xor, running_xor_next;
  logic [flrx_pkg::BYTE_W-1:0]   payload_length, payload_length_next;
  logic                          ready_flag, ready_flag_next;
  logic                          front_select, front_select_next;
  logic [flrx_pkg::POS_W-1:0]    len0, len0_next;
  logic [flrx_pkg::POS_W-1:0]    len1, len1_next;

  // result register
  logic                          r_valid;
  logic                          r_ready;
  logic [flrx_pkg::LEN_W-1:0]    r_length;
  logic                          r_is_read;
  logic                          r_done;
  logic                          r_cerr;
  logic                          r_lerr;

  // step results
  logic                          fire;
  logic                          done, cerr, lerr, is_read;
  logic [flrx_pkg::POS_W-1:0]    pos, pos_stored, len_front;
  logic                          back;
  logic                          can_store;
  logic                          we, re;
  logic [RAM_AW-1:0]             waddr, raddr;
  logic [flrx_pkg::BYTE_W-1:0]   ram_rdata;

  assign fire  = q_valid && (!r_valid || result.ready);
  assign q_pop = fire;

  // back half write position
  assign back       = ~front_select;
  assign pos        = back ? len1 : len0;
  assign len_front  = front_select ? len1 : len0;
  assign can_store  = (pos < flrx_pkg::POS_W'(flrx_pkg::FRAME_DEPTH));
  assign pos_stored = can_store ? pos + 1'b1 : pos;

  // next state for one step
  always_comb begin
    rx_phase_next       = rx_phase;
    hdr_count_next      = hdr_count;
    running_xor_next    = running_xor;
    payload_length_next = payload_length;
    ready_flag_next     = ready_flag;
    front_select_next   = front_select;
    len0_next           = len0;
    len1_next           = len1;
    done                = 1'b0;
    cerr                = 1'b0;
    lerr                = 1'b0;
    is_read             = 1'b0;
    we                  = 1'b0;
    re                  = 1'b0;
    waddr               = {back, pos[flrx_pkg::IDX_W-1:0]};
    raddr               = {front_select, q_head.index[flrx_pkg::IDX_W-1:0]};
    if (fire) begin
      unique case (q_head.op)
        flrx_pkg::OP_BYTE: begin
          unique case (rx_phase)
            HUNT: begin
              if (q_head.is_start) begin
                we               = 1'b1;
                waddr            = {back, {flrx_pkg::IDX_W{1'b0}}};
                running_xor_next = q_head.data;
                rx_phase_next    = GET_LENGTH;
                if (back) begin
                  len1_next = flrx_pkg::POS_W'(1);
                end else begin
                  len0_next = flrx_pkg::POS_W'(1);
                end
              end
            end
            GET_LENGTH: begin
              if (q_head.len_bad) begin
                lerr          = 1'b1;
                rx_phase_next = HUNT;
              end else begin
                we                  = can_store;
                running_xor_next    = running_xor ^ q_head.data;
                payload_length_next = q_head.data;
                hdr_count_next      = 3'd0;
                rx_phase_next       = GET_HEADER;
              end
            end
            GET_HEADER: begin
              we               = can_store;
              running_xor_next = running_xor ^ q_head.data;
              if (hdr_count == HDR_LAST) begin
                rx_phase_next = GET_PAYLOAD;
              end else begin
                hdr_count_next = hdr_count + 1'b1;
              end
            end
            GET_PAYLOAD: begin
              we               = can_store;
              running_xor_next = running_xor ^ q_head.data;
              if (pos_stored >= flrx_pkg::POS_W'(payload_length) +
                                flrx_pkg::POS_W'(flrx_pkg::HEADER_BYTES)) begin
                rx_phase_next = GET_CHECK;
              end
            end
            GET_CHECK: begin
              we            = can_store;
              rx_phase_next = HUNT;
              if (running_xor == q_head.data) begin
                front_select_next = ~front_select;
                ready_flag_next   = 1'b1;
                done              = 1'b1;
              end else begin
                cerr = 1'b1;
              end
            end
            default: rx_phase_next = HUNT;
          endcase
          // byte count follows every stored byte after the start byte
          if (rx_phase != HUNT && !(rx_phase == GET_LENGTH && q_head.len_bad)) begin
            if (back) begin
              len1_next = pos_stored;
            end else begin
              len0_next = pos_stored;
            end
          end
        end
        flrx_pkg::OP_READ: begin
          re      = (flrx_pkg::LEN_W'(q_head.index) < flrx_pkg::LEN_W'(len_front)) &&
                    (flrx_pkg::LEN_W'(q_head.index) <
                     flrx_pkg::LEN_W'(flrx_pkg::FRAME_DEPTH));
          is_read = re;
        end
        flrx_pkg::OP_ACK: ready_flag_next = 1'b0;
        flrx_pkg::OP_NOP: ;
        default: ;
      endcase
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase       <= HUNT;
      hdr_count      <= 3'd0;
      running_xor    <= '0;
      payload_length <= '0;
      ready_flag     <= 1'b0;
      front_select   <= 1'b0;
      len0           <= '0;
      len1           <= '0;
      r_valid        <= 1'b0;
    end else begin
      rx_phase       <= rx_phase_next;
      hdr_count      <= hdr_count_next;
      running_xor    <= running_xor_next;
      payload_length <= payload_length_next;
      ready_flag     <= ready_flag_next;
      front_select   <= front_select_next;
      len0           <= len0_next;
      len1           <= len1_next;
      if (fire) begin
        r_valid   <= 1'b1;
        r_ready   <= ready_flag_next;
        r_length  <= flrx_pkg::LEN_W'(front_select_next ? len1_next : len0_next);
        r_is_read <= is_read;
        r_done    <= done;
        r_cerr    <= cerr;
        r_lerr    <= lerr;
      end else if (result.ready) begin
        r_valid <= 1'b0;
      end
    end
  end

  // double buffered frame store
  flrx_ram #(
    .WIDTH(flrx_pkg::BYTE_W),
    .DEPTH(flrx_pkg::RAM_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(q_head.data),
    .re   (re),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  // result channel
  assign result.valid          = r_valid;
  assign result.frame_ready    = r_ready;
  assign result.frame_length   = r_length;
  assign result.read_data      = r_is_read ? ram_rdata : '0;
  assign result.frame_done     = r_done;
  assign result.checksum_error = r_cerr;
  assign result.length_error   = r_lerr;

endmodule

/* rtl/framed_link_receiver_xor_core.sv */
// top level of the framed link receiver with xor checksum
// path: each item goes through a queue slot and the result register
// throughput: one item per cycle when results are taken, set by the single
//   execute stage that updates receive state and drives one port per item
// reset: synchronous, clears receive state, counts, flags and queue;
//   frame store contents stay undefined and get no clearing pass
module framed_link_receiver_xor_core (
  input  logic                            clk,
  input  logic                            rst,
  flrx_item_if.sink                       item,
  flrx_result_if.source                   result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [flrx_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [flrx_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [flrx_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic [flrx_pkg::BYTE_W-1:0] start_marker;
  logic                        q_valid;
  flrx_pkg::qitem_t            q_head;
  logic                        q_pop;
  logic                        reg_hit;

  // configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[flrx_pkg::CFG_ADDR_W-1:2] == flrx_pkg::REG_START_MARKER);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= flrx_pkg::START_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      start_marker <= pwdata[flrx_pkg::BYTE_W-1:0];
    end
  end

  assign prdata = reg_hit ? flrx_pkg::CFG_DATA_W'(start_marker) : '0;

  // classify and queue
  flrx_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .start_marker(start_marker),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  // execute and deliver
  flrx_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop),
    .result (result)
  );

  // at most one status flag per result
  a_one_status: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> $onehot0({result.frame_done, result.checksum_error,
                               result.length_error}))
    else $error("more than one status flag in a result");

  // a good frame leaves the ready flag set
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.frame_done |-> result.frame_ready)
    else $error("frame done without frame ready");

  // stored length never exceeds one half of the store
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.frame_length <= flrx_pkg::LEN_W'(flrx_pkg::FRAME_DEPTH))
    else $error("frame length beyond store depth");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result offered right after reset");

endmodule
